// ----- sv/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and command codes of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int MAX_ORDER      = 11;
    localparam int AREA_PAGES_MAX = 4096;
    localparam int PAGE_W         = 20;
    localparam int CNT_W          = 13;
    localparam int ORD_W          = 4;
    localparam int ADDR_W         = 12;
    localparam int TAG_W          = 5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOBLK   = 3'd1;
    localparam logic [2:0] ST_BADORD  = 3'd2;
    localparam logic [2:0] ST_MISALGN = 3'd3;
    localparam logic [2:0] ST_OUTSIDE = 3'd4;
    localparam logic [2:0] ST_DOUBLE  = 3'd5;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic CFG_AREA_BASE  = 1'b0;
    localparam logic CFG_AREA_PAGES = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ORD_W-1:0]  req_order;
        logic [PAGE_W-1:0] page_number;
    } bpa_in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [PAGE_W-1:0] granted_page;
        logic [CNT_W-1:0]  free_total;
    } bpa_out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_DECIDE,
        OP_SCAN,
        OP_POST,
        OP_TAKE,
        OP_SPLIT,
        OP_MRD,
        OP_MERGE,
        OP_MARK,
        OP_FIN
    } bpa_op_t;

    typedef struct packed {
        logic clear_last;
        logic scan_done;
        logic bad_ord;
        logic mode;
        logic chk_fail;
        logic found;
        logic hit;
        logic split_more;
        logic merge_try;
        logic merge_hit;
        logic out_free;
    } bpa_stat_t;

endpackage

// ----- sv/buddy_page_allocator_core.sv -----
// ----------------------------------------------------------------------------
// buddy_page_allocator_core
// Binary buddy page allocator over one aligned area of up to 4096 pages.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 4096-entry tag memory to zero, one entry
// a cycle, and accepts no item until the sweep ends; config writes are
// taken at any time. Each item yields exactly one result. An allocate
// scans every tag once, one memory read a cycle, to find the lowest-addressed
// free block of the smallest fitting order, then splits it, one tag write per
// order split off. A free first checks order, range and alignment, scans all
// tags for an overlapping free block, then merges with its buddy, up to ten
// levels, and writes the new head. All of these steps share the one tag
// memory. The result sits in an output register, so a new item is taken while
// an earlier result waits.
// ----------------------------------------------------------------------------
module buddy_page_allocator_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  bpa_pkg::bpa_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output bpa_pkg::bpa_out_t          m_data,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [bpa_pkg::PAGE_W-1:0] cfg_wdata
);
    import bpa_pkg::*;

    bpa_op_t   op;
    bpa_stat_t st;

    // sequencer: owns the item flow
    bpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .st      (st),
        .op      (op),
        .idle    (s_ready)
    );

    // datapath: tags, counters, result register
    bpa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .st        (st),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );
endmodule

// ----- sv/bpa_ram.sv -----
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/bpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: clears the tag memory, then steps each request through
// check, scan, split or merge, and result.
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  bpa_pkg::bpa_stat_t st,
    output bpa_pkg::bpa_op_t   op,
    output logic               idle
);
    import bpa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECIDE, S_SCAN, S_POST, S_TAKE,
        S_SPLIT, S_MRD, S_MCHK, S_MARK, S_FIN
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_CLEAR: begin
                op = OP_CLEAR;
                if (st.clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    op         = OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                op = OP_DECIDE;
                if (st.bad_ord || (st.mode == MODE_FREE && st.chk_fail)) state_next = S_FIN;
                else state_next = S_SCAN;
            end
            S_SCAN: begin
                op = OP_SCAN;
                if (st.scan_done) state_next = S_POST;
            end
            S_POST: begin
                op = OP_POST;
                if (st.mode == MODE_ALLOC) state_next = st.found ? S_TAKE : S_FIN;
                else state_next = st.hit ? S_FIN : S_MRD;
            end
            S_TAKE: begin
                op         = OP_TAKE;
                state_next = S_SPLIT;
            end
            S_SPLIT: begin
                if (st.split_more) op = OP_SPLIT;
                else state_next = S_FIN;
            end
            S_MRD: begin
                if (st.merge_try) begin
                    op         = OP_MRD;
                    state_next = S_MCHK;
                end else begin
                    state_next = S_MARK;
                end
            end
            S_MCHK: begin
                if (st.merge_hit) begin
                    op         = OP_MERGE;
                    state_next = S_MRD;
                end else begin
                    state_next = S_MARK;
                end
            end
            S_MARK: begin
                op         = OP_MARK;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (st.out_free) begin
                    op         = OP_FIN;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign idle = (state_reg == S_IDLE);
endmodule

// ----- sv/bpa_dp.sv -----
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath: configuration, request registers, tag memory, scan, split and
// merge arithmetic, free page count and result register.
// ----------------------------------------------------------------------------
module bpa_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bpa_pkg::bpa_op_t           op,
    output bpa_pkg::bpa_stat_t         st,
    input  bpa_pkg::bpa_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output bpa_pkg::bpa_out_t          m_data,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [bpa_pkg::PAGE_W-1:0] cfg_wdata
);
    import bpa_pkg::*;

    logic [PAGE_W-1:0] base_reg;
    logic [CNT_W-1:0]  pages_reg;
    logic              mode_reg;
    logic [ORD_W-1:0]  ord_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [ADDR_W-1:0] off_reg;
    logic [CNT_W-1:0]  ptr_reg;
    logic              scan_vld_reg;
    logic [ADDR_W-1:0] sa_reg;
    logic              found_reg;
    logic [ORD_W-1:0]  bestk_reg;
    logic [ADDR_W-1:0] bestp_reg;
    logic              hit_reg;
    logic [ORD_W-1:0]  j_reg;
    logic [ORD_W-1:0]  o_reg;
    logic [CNT_W-1:0]  free_reg;
    logic [2:0]        res_reg;
    logic              m_valid_reg;
    bpa_out_t          out_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [TAG_W-1:0]  wdata, rdata;

    logic [CNT_W-1:0]  lim, size, bsz;
    logic [PAGE_W-1:0] off_full;
    logic              outside, misaligned;
    logic [ADDR_W-1:0] bud;
    logic [13:0]       blk_end;
    logic [16:0]       tag_end;
    logic              tag_ok, tag_hit;
    logic [ORD_W-1:0]  jm1;

    bpa_ram #(.DATA_W(TAG_W), .DEPTH(AREA_PAGES_MAX)) u_tags (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign lim  = (pages_reg > CNT_W'(AREA_PAGES_MAX)) ? CNT_W'(AREA_PAGES_MAX) : pages_reg;
    assign size = CNT_W'(1) << ord_reg;
    assign bsz  = CNT_W'(1) << o_reg;
    assign bud  = off_reg ^ bsz[ADDR_W-1:0];
    assign jm1  = j_reg - ORD_W'(1);

    // free request range and alignment checks
    assign off_full   = page_reg - base_reg;
    assign outside    = (page_reg < base_reg) || (off_full >= PAGE_W'(lim))
                     || (PAGE_W'(size) > (PAGE_W'(lim) - off_full));
    assign misaligned = |(off_full[CNT_W-1:0] & (size - CNT_W'(1)));

    // scan evaluation of the tag read last cycle
    assign blk_end = {2'b00, off_reg} + 14'(size);
    assign tag_end = 17'(sa_reg) + (17'(1) << rdata[ORD_W-1:0]);
    assign tag_ok  = rdata[TAG_W-1] && (rdata[ORD_W-1:0] >= ord_reg)
                  && (!found_reg || rdata[ORD_W-1:0] < bestk_reg);
    assign tag_hit = rdata[TAG_W-1] && (14'(sa_reg) < blk_end) && (17'(off_reg) < tag_end);

    always_comb begin
        st.clear_last = (ptr_reg == CNT_W'(AREA_PAGES_MAX - 1));
        st.scan_done  = (ptr_reg == CNT_W'(AREA_PAGES_MAX)) && !scan_vld_reg;
        st.bad_ord    = (ord_reg >= ORD_W'(MAX_ORDER));
        st.mode       = mode_reg;
        st.chk_fail   = outside || misaligned;
        st.found      = found_reg;
        st.hit        = hit_reg;
        st.split_more = (j_reg > ord_reg);
        st.merge_try  = (5'(o_reg) + 5'd1 < 5'(MAX_ORDER))
                     && !(CNT_W'(bud) >= lim || bsz > (lim - CNT_W'(bud)));
        st.merge_hit  = (rdata == {1'b1, o_reg});
        st.out_free   = !m_valid_reg || m_ready;
    end

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        unique case (op)
            OP_CLEAR: begin
                we    = 1'b1;
                waddr = ptr_reg[ADDR_W-1:0];
            end
            OP_SCAN:  raddr = ptr_reg[ADDR_W-1:0];
            OP_TAKE: begin
                we    = 1'b1;
                waddr = bestp_reg;
            end
            OP_SPLIT: begin
                we    = 1'b1;
                waddr = bestp_reg + ADDR_W'(CNT_W'(1) << jm1);
                wdata = {1'b1, jm1};
            end
            OP_MRD:   raddr = bud;
            OP_MERGE: begin
                we    = 1'b1;
                waddr = bud;
            end
            OP_MARK: begin
                we    = 1'b1;
                waddr = off_reg;
                wdata = {1'b1, o_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            pages_reg    <= '0;
            free_reg     <= '0;
            ptr_reg      <= '0;
            scan_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_AREA_BASE:  base_reg  <= cfg_wdata;
                    CFG_AREA_PAGES: pages_reg <= cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            // raise on a new result, drop once the current one is taken
            if (op == OP_FIN) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (op)
                OP_CLEAR: ptr_reg <= ptr_reg + CNT_W'(1);
                OP_LOAD: begin
                    mode_reg     <= s_data.mode;
                    ord_reg      <= s_data.req_order;
                    page_reg     <= s_data.page_number;
                    ptr_reg      <= '0;
                    scan_vld_reg <= 1'b0;
                    found_reg    <= 1'b0;
                    hit_reg      <= 1'b0;
                end
                OP_DECIDE: begin
                    off_reg <= off_full[ADDR_W-1:0];
                    if (ord_reg >= ORD_W'(MAX_ORDER)) res_reg <= ST_BADORD;
                    else if (mode_reg == MODE_FREE && outside) res_reg <= ST_OUTSIDE;
                    else if (mode_reg == MODE_FREE && misaligned) res_reg <= ST_MISALGN;
                    else res_reg <= ST_OK;
                end
                OP_SCAN: begin
                    // read one tag a cycle, judge it the cycle after
                    if (ptr_reg != CNT_W'(AREA_PAGES_MAX)) begin
                        ptr_reg      <= ptr_reg + CNT_W'(1);
                        sa_reg       <= ptr_reg[ADDR_W-1:0];
                        scan_vld_reg <= 1'b1;
                    end else begin
                        scan_vld_reg <= 1'b0;
                    end
                    if (scan_vld_reg) begin
                        if (mode_reg == MODE_ALLOC && tag_ok) begin
                            found_reg <= 1'b1;
                            bestk_reg <= rdata[ORD_W-1:0];
                            bestp_reg <= sa_reg;
                        end
                        if (mode_reg == MODE_FREE && tag_hit) hit_reg <= 1'b1;
                    end
                end
                OP_POST: begin
                    j_reg <= bestk_reg;
                    o_reg <= ord_reg;
                    if (mode_reg == MODE_ALLOC) res_reg <= found_reg ? ST_OK : ST_NOBLK;
                    else res_reg <= hit_reg ? ST_DOUBLE : ST_OK;
                end
                OP_TAKE:  free_reg <= free_reg - size;
                OP_SPLIT: j_reg <= jm1;
                OP_MERGE: begin
                    off_reg <= off_reg & ~bsz[ADDR_W-1:0];
                    o_reg   <= o_reg + ORD_W'(1);
                end
                OP_MARK:  free_reg <= free_reg + size;
                OP_FIN: begin
                    out_reg.status       <= res_reg;
                    out_reg.granted_page <= (mode_reg == MODE_ALLOC && res_reg == ST_OK)
                                          ? base_reg + PAGE_W'(bestp_reg) : '0;
                    out_reg.free_total   <= free_reg;
                end
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
endmodule

// ----- sv/bpa_checker.sv -----
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks on the allocator's result channel.
// ----------------------------------------------------------------------------
module bpa_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input bpa_pkg::bpa_out_t m_data
);
    import bpa_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= ST_DOUBLE)
        else $error("undefined status code");

    a_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.granted_page == '0)
        else $error("page granted on a failed request");
endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buddy page allocator core.
// ----------------------------------------------------------------------------
// Drives allocate and free requests through the valid/ready input channel.
// A behavioral copy of the allocator (tag memory, per-order counts, free
// page total) predicts the result of every item at the moment it is taken.
// Results are checked in order against that prediction. The area registers
// are rewritten between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import bpa_pkg::*;

    typedef struct {
        int page;
        int ord;
    } held_blk_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    bpa_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bpa_out_t m_data;
    logic              cfg_we = 1'b0;
    logic              cfg_index = CFG_AREA_BASE;
    logic [PAGE_W-1:0] cfg_wdata = '0;

    // Shadow allocator state
    logic [TAG_W-1:0] tag_mem [0:AREA_PAGES_MAX-1];
    logic [CNT_W-1:0] order_cnt [0:MAX_ORDER-1];
    logic [CNT_W-1:0] free_cnt;
    int               area_base_r;
    int               area_pages_r;

    bpa_in_t   pending_reqs [$];
    bpa_out_t  expected_results [$];
    held_blk_t held_blocks [$];

    bit quiet = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    bit held_once = 1'b0;
    int results_seen = 0;
    int n_errors = 0;
    int n_alloc_ok = 0;
    int n_free_ok = 0;
    int n_rejected = 0;

    buddy_page_allocator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Compute the result of one request and advance the shadow state.
    function automatic bpa_out_t predict_result(bpa_in_t it);
        bpa_out_t r;
        int ord, k, p, j, lim, size, off, o, bsz, bud, sz, page;
        bit hit;
        r    = '0;
        ord  = it.req_order;
        hit  = 1'b0;
        if (ord >= MAX_ORDER) begin
            r.status = ST_BADORD;
        end else if (it.mode == MODE_ALLOC) begin
            r.status = ST_NOBLK;
            // smallest fitting order first, lowest address within it
            for (k = ord; k < MAX_ORDER && !hit; k++) begin
                for (p = 0; p < AREA_PAGES_MAX && !hit; p++) begin
                    if (tag_mem[p] == {1'b1, 4'(k)}) begin
                        hit = 1'b1;
                        tag_mem[p] = '0;
                        order_cnt[k] = order_cnt[k] - 1'b1;
                        // hand the upper halves back, one per order
                        for (j = k; j > ord; j--) begin
                            tag_mem[p + (1 << (j - 1))] = {1'b1, 4'(j - 1)};
                            order_cnt[j - 1] = order_cnt[j - 1] + 1'b1;
                        end
                        free_cnt = free_cnt - CNT_W'(1 << ord);
                        r.status = ST_OK;
                        r.granted_page = PAGE_W'(area_base_r + p);
                        held_blocks.push_back('{area_base_r + p, ord});
                    end
                end
            end
        end else begin
            lim  = (area_pages_r > AREA_PAGES_MAX) ? AREA_PAGES_MAX : area_pages_r;
            size = 1 << ord;
            page = it.page_number;
            off  = page - area_base_r;
            if (page < area_base_r || off >= lim || size > lim - off) begin
                r.status = ST_OUTSIDE;
            end else if ((off & (size - 1)) != 0) begin
                r.status = ST_MISALGN;
            end else begin
                for (p = 0; p < AREA_PAGES_MAX; p++) begin
                    if (tag_mem[p][4]) begin
                        sz = 1 << tag_mem[p][3:0];
                        if (p < off + size && off < p + sz)
                            hit = 1'b1;
                    end
                end
                if (hit) begin
                    r.status = ST_DOUBLE;
                end else begin
                    // merge upward while the buddy is free, same order, in area
                    o = ord;
                    while (o + 1 < MAX_ORDER) begin
                        bsz = 1 << o;
                        bud = off ^ bsz;
                        if (bud >= lim || bsz > lim - bud)
                            break;
                        if (tag_mem[bud] != {1'b1, 4'(o)})
                            break;
                        tag_mem[bud] = '0;
                        order_cnt[o] = order_cnt[o] - 1'b1;
                        off = off & ~bsz;
                        o++;
                    end
                    tag_mem[off] = {1'b1, 4'(o)};
                    order_cnt[o] = order_cnt[o] + 1'b1;
                    free_cnt = free_cnt + CNT_W'(size);
                    r.status = ST_OK;
                end
            end
        end
        if (r.status == ST_OK) begin
            if (it.mode == MODE_ALLOC) n_alloc_ok++;
            else n_free_ok++;
        end else begin
            n_rejected++;
        end
        r.free_total = free_cnt;
        return r;
    endfunction

    // Sender: hold an offered item until taken, then advance or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(predict_result(s_data));
            if (s_valid && !s_ready) begin
                // hold the payload until the block takes it
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(1, 15) - 1;
                    s_valid  <= 1'b0;
                end else begin
                    s_data  <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each result against the oldest prediction.
    always @(posedge aclk) begin
        bpa_out_t exp_r;
        logic     nxt_ready;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d page=%h total=%0d",
                             $time, m_data.status, m_data.granted_page, m_data.free_total);
                    n_errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_data.status !== exp_r.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, m_data.status);
                        n_errors++;
                    end
                    if (m_data.granted_page !== exp_r.granted_page) begin
                        $display("%0t: granted_page expected %h actual %h",
                                 $time, exp_r.granted_page, m_data.granted_page);
                        n_errors++;
                    end
                    if (m_data.free_total !== exp_r.free_total) begin
                        $display("%0t: free_total expected %0d actual %0d",
                                 $time, exp_r.free_total, m_data.free_total);
                        n_errors++;
                    end
                end
            end
            nxt_ready = 1'b1;
            if (hold_left > 0) begin
                // long back-pressure: let the block fill and stall its input
                hold_left <= hold_left - 1;
                nxt_ready = 1'b0;
            end else if (!held_once && results_seen >= 300) begin
                held_once <= 1'b1;
                hold_left <= 20000;
                nxt_ready = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                nxt_ready = 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(1, 15) - 1;
                nxt_ready = 1'b0;
            end
            m_ready <= nxt_ready;
        end
    end

    task automatic add_req(logic mode, int ord, int page);
        bpa_in_t it;
        it.mode        = mode;
        it.req_order   = ORD_W'(ord);
        it.page_number = PAGE_W'(page);
        pending_reqs.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
    endtask

    task automatic write_cfg(logic idx, int value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= PAGE_W'(value);
        if (idx == CFG_AREA_BASE) area_base_r = value & 32'hFFFFF;
        else area_pages_r = value & 32'h1FFF;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed traffic: allocations and frees of held blocks, some noise.
    task automatic run_random(int n_items);
        int i, sel, idx, ord;
        held_blk_t b;
        for (i = 0; i < n_items; i++) begin
            sel = $urandom_range(0, 99);
            if (sel >= 45 && sel < 88 && held_blocks.size() > 0) begin
                idx = $urandom_range(0, held_blocks.size() - 1);
                b = held_blocks[idx];
                if (sel < 85) begin
                    held_blocks.delete(idx);
                    add_req(MODE_FREE, b.ord, b.page);
                end else begin
                    // broken free: wrong offset, and sometimes also wrong order, of a live block
                    add_req(MODE_FREE, b.ord + $urandom_range(0, 1), b.page + 1);
                end
            end else if (sel < 88) begin
                ord = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10)
                                                  : $urandom_range(0, 3);
                add_req(MODE_ALLOC, ord, $urandom_range(0, 20'hFFFFF));
            end else if (sel < 94) begin
                add_req(MODE_FREE, $urandom_range(0, 10),
                        area_base_r + ($urandom_range(0, 4095) & ~3));
            end else begin
                add_req($urandom_range(0, 1), $urandom_range(0, 15),
                        $urandom_range(0, 20'hFFFFF));
            end
            // drain in small batches so frees only name blocks already granted
            if (i % 8 == 7)
                wait_drained();
        end
        wait_drained();
    endtask

    task automatic release_all();
        held_blk_t b;
        while (held_blocks.size() > 0) begin
            b = held_blocks.pop_front();
            add_req(MODE_FREE, b.ord, b.page);
        end
        wait_drained();
    endtask

    initial begin
        int i;
        int bases [6];
        int sizes [6];
        int counts [6];
        bases  = '{32'h00000, 32'hFF800, 32'h2A800, 32'h55000, 32'hFFFFF, 32'h00000};
        sizes  = '{4096, 4096, 100, 8191, 3, 0};
        counts = '{250, 200, 200, 200, 70, 10};
        for (i = 0; i < AREA_PAGES_MAX; i++) tag_mem[i] = '0;
        for (i = 0; i < MAX_ORDER; i++) order_cnt[i] = '0;
        free_cnt     = '0;
        area_base_r  = 0;
        area_pages_r = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty area straight out of reset
        add_req(MODE_ALLOC, 0, 0);
        add_req(MODE_FREE, 0, 0);
        add_req(MODE_ALLOC, 15, 0);
        wait_drained();

        write_cfg(CFG_AREA_BASE, 32'h00800);
        write_cfg(CFG_AREA_PAGES, 4096);
        add_req(MODE_FREE, 10, 32'h00800);
        add_req(MODE_FREE, 10, 32'h00800);         // same block again
        add_req(MODE_FREE, 0, 32'h00805);          // inside a free block
        add_req(MODE_FREE, 3, 32'h01004);          // misaligned
        add_req(MODE_FREE, 0, 32'h007FF);          // below the area
        add_req(MODE_FREE, 1, 32'h017FF);          // runs past the end
        add_req(MODE_FREE, 0, 32'hFFFFF);
        add_req(MODE_FREE, 11, 32'h00800);         // bad order
        add_req(MODE_ALLOC, 15, 0);
        add_req(MODE_FREE, 9, 32'h00C00);
        add_req(MODE_FREE, 9, 32'h00E00);          // merges into order 10
        add_req(MODE_FREE, 10, 32'h01000);
        add_req(MODE_FREE, 0, 32'h01400);
        add_req(MODE_FREE, 0, 32'h01401);          // merges one level
        add_req(MODE_ALLOC, 0, 0);                 // splits from a larger order
        add_req(MODE_ALLOC, 10, 0);
        add_req(MODE_ALLOC, 10, 0);
        add_req(MODE_ALLOC, 10, 0);
        add_req(MODE_ALLOC, 10, 0);                // nothing that large is left
        add_req(MODE_ALLOC, 1, 0);
        wait_drained();
        release_all();

        for (i = 0; i < 6; i++) begin
            repeat (20) @(posedge aclk);
            write_cfg(CFG_AREA_BASE, bases[i]);
            write_cfg(CFG_AREA_PAGES, sizes[i]);
            if (i == 0) begin
                // seed the whole area with top-order blocks
                for (int b = 0; b < 4; b++) add_req(MODE_FREE, 10, b * 1024);
                wait_drained();
            end
            if (i == 5) quiet = 1'b1;
            run_random(counts[i]);
            if (i < 5) release_all();
        end

        wait_drained();
        repeat (50) @(posedge aclk);
        $display("Covered %0d results: %0d grants, %0d frees, %0d rejected requests,",
                 results_seen, n_alloc_ok, n_free_ok, n_rejected);
        $display("over seven area settings including empty, shrunk and clamped areas.");
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- buddy_page_allocator_core.f -----
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/bpa_ctrl.sv
sv/bpa_dp.sv
sv/buddy_page_allocator_core.sv
sv/bpa_checker.sv
tb/sv/tb.sv
